[hdl/dprs_pkg.sv]
// ----------------------------------------------------------------------------
// dprs_pkg
// Shared types and constants for the dirty page refresh scheduler.
// ----------------------------------------------------------------------------
package dprs_pkg;

    localparam int unsigned PAGE_SLOTS        = 8;
    localparam int unsigned PAGE_IDX_W        = 3;
    localparam int unsigned PAGE_COUNT_W      = 4;
    localparam int unsigned DEV_ADDR_W        = 7;
    localparam int unsigned CFG_DATA_W        = 7;
    localparam int unsigned CFG_INDEX_W       = 1;
    localparam int unsigned BYTE_COUNT_W      = 8;
    localparam int unsigned COUNTER_W         = 32;

    localparam int unsigned MAX_PAGES_DEFAULT     = 8;
    localparam int unsigned DISPLAY_WIDTH_DEFAULT = 128;

    localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RESET = 4'd8;
    localparam logic [DEV_ADDR_W-1:0]   DEV_ADDR_RESET   = 7'd60;
    localparam logic [BYTE_COUNT_W-1:0] HEADER_BYTES     = 8'd4;

    typedef logic [1:0] op_t;
    localparam op_t OP_MARK_DIRTY = 2'd0;
    localparam op_t OP_REFRESH    = 2'd1;
    localparam op_t OP_COMPLETE   = 2'd2;
    localparam op_t OP_ERROR      = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEV_ADDR   = 1'd1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

endpackage

[hdl/dirty_page_refresh_scheduler.sv]
// ----------------------------------------------------------------------------
// dirty_page_refresh_scheduler
// Round-robin scheduler of display page refresh transfers.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one event word per handshake: mark pages dirty,
//   refresh request, transfer complete or transfer error. Every accepted
//   word yields exactly one result word on the m_ channel, saying whether a
//   header or pixel data transfer should start, for which page and with how
//   many bytes, plus the busy flag and completion and error counters.
//   m_valid rises in the cycle after accept. A new word is taken every
//   cycle unless a stalled result holds s_ready low; the round-robin pick
//   over eight dirty bits is combinational, before the result register.
//   s_ready is high while the result register is empty or being drained, so
//   a stalled receiver holds the result and back-pressures the event side.
//   cfg_we writes page_count (index 0) or device_address (index 1) at once;
//   write only while no result is pending.
//   Reset (aresetn low, synchronous) clears dirty, busy, active page and both
//   counters, sets page_count to 8 and device_address to 60.
// ----------------------------------------------------------------------------
module dirty_page_refresh_scheduler #(
    parameter int unsigned MAX_PAGES     = dprs_pkg::MAX_PAGES_DEFAULT,
    parameter int unsigned DISPLAY_WIDTH = dprs_pkg::DISPLAY_WIDTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [dprs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dprs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_operation,
    input  logic [7:0]                           s_page_mask,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_start_transfer,
    output logic                                 m_transfer_kind,
    output logic [2:0]                           m_page_index,
    output logic [7:0]                           m_byte_count,
    output logic [7:0]                           m_bus_address_byte,
    output logic                                 m_busy_flag,
    output logic [31:0]                          m_completions_seen,
    output logic [31:0]                          m_errors_seen
);
    import dprs_pkg::*;

    localparam logic [PAGE_COUNT_W-1:0] MaxPagesW  = PAGE_COUNT_W'(MAX_PAGES);
    localparam logic [BYTE_COUNT_W-1:0] DataBytes  = BYTE_COUNT_W'(DISPLAY_WIDTH + 1);

    // configuration
    logic [PAGE_COUNT_W-1:0] page_count_reg;
    logic [DEV_ADDR_W-1:0]   dev_addr_reg;

    // scheduler state
    logic [PAGE_SLOTS-1:0]   dirty_reg, dirty_next;
    logic [PAGE_SLOTS-1:0]   busy_reg, busy_next;
    logic [PAGE_IDX_W-1:0]   active_reg, active_next;
    logic [COUNTER_W-1:0]    compl_reg, compl_next;
    logic [COUNTER_W-1:0]    err_reg, err_next;

    // result register
    logic                    out_valid_reg;
    logic                    start_reg, start_next;
    logic                    kind_reg, kind_next;
    logic [PAGE_IDX_W-1:0]   page_reg, page_next;
    logic [BYTE_COUNT_W-1:0] bytes_reg, bytes_next;
    logic [7:0]              addr_byte_reg;
    logic                    busy_flag_reg;

    logic                    accept;
    logic [PAGE_COUNT_W-1:0] pages_used;
    logic [PAGE_SLOTS-1:0]   page_window;
    logic [PAGE_SLOTS-1:0]   active_bit;
    logic [PAGE_SLOTS-1:0]   busy_base;
    logic [PAGE_SLOTS-1:0]   dirty_base;
    logic [PAGE_SLOTS-1:0]   dirty_masked;
    logic                    data_case;
    logic                    refresh_en;
    logic [PAGE_IDX_W-1:0]   search_start;
    logic [PAGE_IDX_W-1:0]   pick;
    logic [PAGE_IDX_W-1:0]   cand;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pages_used = (page_count_reg > MaxPagesW) ? MaxPagesW : page_count_reg;
        for (int i = 0; i < PAGE_SLOTS; i++) begin
            page_window[i] = (PAGE_COUNT_W'(i) < pages_used);
        end
        active_bit = '0;
        active_bit[active_reg] = 1'b1;

        // first step of the search wraps to page 0 at the end of the window
        if ((PAGE_COUNT_W'(active_reg) + PAGE_COUNT_W'(1)) >= pages_used) begin
            search_start = '0;
        end else begin
            search_start = active_reg + PAGE_IDX_W'(1);
        end
    end

    always_comb begin
        dirty_base  = dirty_reg;
        busy_base   = busy_reg;
        compl_next  = compl_reg;
        err_next    = err_reg;
        data_case   = 1'b0;
        refresh_en  = 1'b0;
        start_next  = 1'b0;
        kind_next   = KIND_HEADER;
        page_next   = '0;
        bytes_next  = '0;

        unique case (s_operation)
            OP_MARK_DIRTY: begin
                dirty_base = dirty_reg | s_page_mask;
            end
            OP_REFRESH: begin
                refresh_en = 1'b1;
            end
            OP_COMPLETE: begin
                compl_next = compl_reg + COUNTER_W'(1);
                data_case  = |(busy_reg & dirty_reg & active_bit);
                if (data_case) begin
                    start_next = 1'b1;
                    kind_next  = KIND_DATA;
                    page_next  = active_reg;
                    bytes_next = DataBytes;
                    dirty_base = dirty_reg & ~active_bit;
                end else begin
                    busy_base  = busy_reg & ~active_bit;
                    refresh_en = 1'b1;
                end
            end
            OP_ERROR: begin
                err_next = err_reg + COUNTER_W'(1);
            end
            default: begin
            end
        endcase

        dirty_masked = dirty_base & page_window;

        // rotating priority pick, nearest dirty page after the active one wins
        pick = search_start;
        for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
            cand = search_start + PAGE_IDX_W'(i);
            if (dirty_masked[cand]) begin
                pick = cand;
            end
        end

        dirty_next  = dirty_base;
        busy_next   = busy_base;
        active_next = active_reg;
        if (refresh_en && (busy_base == '0)) begin
            dirty_next = dirty_masked;
            if (dirty_masked != '0) begin
                active_next       = pick;
                busy_next         = busy_base;
                busy_next[pick]   = 1'b1;
                start_next        = 1'b1;
                kind_next         = KIND_HEADER;
                page_next         = pick;
                bytes_next        = HEADER_BYTES;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_count_reg <= PAGE_COUNT_RESET;
            dev_addr_reg   <= DEV_ADDR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PAGE_COUNT: page_count_reg <= cfg_wdata[PAGE_COUNT_W-1:0];
                CFG_DEV_ADDR:   dev_addr_reg   <= cfg_wdata[DEV_ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg     <= '0;
            busy_reg      <= '0;
            active_reg    <= '0;
            compl_reg     <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                dirty_reg  <= dirty_next;
                busy_reg   <= busy_next;
                active_reg <= active_next;
                compl_reg  <= compl_next;
                err_reg    <= err_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            start_reg     <= start_next;
            kind_reg      <= kind_next;
            page_reg      <= page_next;
            bytes_reg     <= bytes_next;
            addr_byte_reg <= {dev_addr_reg, 1'b0};
            busy_flag_reg <= |busy_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_start_transfer   = start_reg;
    assign m_transfer_kind    = kind_reg;
    assign m_page_index       = page_reg;
    assign m_byte_count       = bytes_reg;
    assign m_bus_address_byte = addr_byte_reg;
    assign m_busy_flag        = busy_flag_reg;
    assign m_completions_seen = compl_reg;
    assign m_errors_seen      = err_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dirty page refresh scheduler. A short table of
// events (some with the result typed in) walks through the corner cases, then
// phases of random events under fixed, later random register settings follow.
// Result fields are checked against an in-bench scheduler model or typed values.
// ----------------------------------------------------------------------------
module tb;
    import dprs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_ITEMS = 50;
    localparam int unsigned PLAN_LEN    = 32;
    localparam logic [7:0]  DATA_BYTES  = 8'(DISPLAY_WIDTH_DEFAULT + 1);
    localparam logic [7:0]  NO_BYTES    = 8'd0;

    typedef struct packed {
        logic        start;
        logic        kind;
        logic [2:0]  page;
        logic [7:0]  bytes;
        logic [7:0]  addr;
        logic        busy;
        logic [31:0] comps;
        logic [31:0] errs;
    } xfer_result_t;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_val;
        op_t                    op;
        logic [7:0]             mask;
        bit                     typed;
        logic                   t_start;
        logic                   t_kind;
        logic [2:0]             t_page;
        logic [7:0]             t_bytes;
        logic                   t_busy;
    } plan_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_operation = OP_MARK_DIRTY;
    logic [7:0]             s_page_mask = 8'h00;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic                   m_start_transfer;
    logic                   m_transfer_kind;
    logic [2:0]             m_page_index;
    logic [7:0]             m_byte_count;
    logic [7:0]             m_bus_address_byte;
    logic                   m_busy_flag;
    logic [31:0]            m_completions_seen;
    logic [31:0]            m_errors_seen;

    dirty_page_refresh_scheduler u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_page_mask        (s_page_mask),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_start_transfer   (m_start_transfer),
        .m_transfer_kind    (m_transfer_kind),
        .m_page_index       (m_page_index),
        .m_byte_count       (m_byte_count),
        .m_bus_address_byte (m_bus_address_byte),
        .m_busy_flag        (m_busy_flag),
        .m_completions_seen (m_completions_seen),
        .m_errors_seen      (m_errors_seen)
    );

    // scheduler model state, reset values
    logic [3:0]  pg_count    = PAGE_COUNT_RESET;
    logic [6:0]  dev_addr    = DEV_ADDR_RESET;
    logic [7:0]  dirty_q     = 8'h00;
    logic [7:0]  busy_q      = 8'h00;
    logic [2:0]  cur_page    = 3'd0;
    logic [31:0] done_count  = 32'd0;
    logic [31:0] fault_count = 32'd0;

    xfer_result_t pending_requests [$];
    int unsigned  fail_count = 0;
    int unsigned  cycles     = 0;
    bit           tx_quiet   = 1'b0;

    // corner-case walk; typed rows carry the transfer fields and busy flag
    plan_row_t plan [PLAN_LEN] = '{
        '{0, 0, 7'd0, OP_ERROR,      8'hFF, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_REFRESH,    8'h00, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_MARK_DIRTY, 8'hFF, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_REFRESH,    8'h00, 1, 1, KIND_HEADER, 3'd1, HEADER_BYTES, 1},
        '{0, 0, 7'd0, OP_REFRESH,    8'h00, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 1},
        '{0, 0, 7'd0, OP_ERROR,      8'h00, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 1},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 1, 1, KIND_DATA,   3'd1, DATA_BYTES, 1},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 1, 1, KIND_HEADER, 3'd2, HEADER_BYTES, 1},
        '{0, 0, 7'd0, OP_MARK_DIRTY, 8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{1, CFG_PAGE_COUNT, 7'd2, OP_MARK_DIRTY, 8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        // active page beyond the count wraps to page 0
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 1, 1, KIND_HEADER, 3'd0, HEADER_BYTES, 1},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        // bit 7 lies beyond the count until the refresh masks it away
        '{0, 0, 7'd0, OP_MARK_DIRTY, 8'h82, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_REFRESH,    8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{1, CFG_PAGE_COUNT, 7'd0, OP_MARK_DIRTY, 8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_MARK_DIRTY, 8'hFF, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_REFRESH,    8'h00, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        // count of 15 saturates to eight pages
        '{1, CFG_PAGE_COUNT, 7'h7F, OP_MARK_DIRTY, 8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{1, CFG_DEV_ADDR,   7'h7F, OP_MARK_DIRTY, 8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_MARK_DIRTY, 8'h80, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_REFRESH,    8'h00, 1, 1, KIND_HEADER, 3'd7, HEADER_BYTES, 1},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 1, 1, KIND_DATA,   3'd7, DATA_BYTES, 1},
        '{0, 0, 7'd0, OP_COMPLETE,   8'h00, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{1, CFG_DEV_ADDR,   7'h00, OP_MARK_DIRTY, 8'h00, 0, 0, KIND_HEADER, 3'd0, NO_BYTES, 0},
        '{0, 0, 7'd0, OP_ERROR,      8'h00, 1, 0, KIND_HEADER, 3'd0, NO_BYTES, 0}
    };

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // refresh attempt: round-robin pick of the next dirty page after cur_page
    function automatic void pick_next_page(inout xfer_result_t r);
        int unsigned n;
        int unsigned p;
        int unsigned k;
        int unsigned in_use;
        n = (pg_count > 4'd8) ? 8 : int'(pg_count);
        if (busy_q != 8'h00) return;
        in_use = (1 << n) - 1;
        dirty_q = dirty_q & in_use[7:0];
        if (dirty_q == 8'h00) return;
        p = cur_page;
        for (k = 0; k < n; k++) begin
            p = (p + 1 >= n) ? 0 : p + 1;
            if (dirty_q[p]) break;
        end
        cur_page = p[2:0];
        busy_q[cur_page] = 1'b1;
        r.start = 1'b1;
        r.kind  = KIND_HEADER;
        r.page  = cur_page;
        r.bytes = HEADER_BYTES;
    endfunction

    function automatic xfer_result_t schedule_event(op_t op, logic [7:0] mask);
        xfer_result_t r;
        r = '0;
        case (op)
            OP_MARK_DIRTY: dirty_q = dirty_q | mask;
            OP_REFRESH:    pick_next_page(r);
            OP_COMPLETE: begin
                done_count = done_count + 32'd1;
                if (busy_q[cur_page] && dirty_q[cur_page]) begin
                    r.start = 1'b1;
                    r.kind  = KIND_DATA;
                    r.page  = cur_page;
                    r.bytes = DATA_BYTES;
                    dirty_q[cur_page] = 1'b0;
                end else begin
                    busy_q[cur_page] = 1'b0;
                    pick_next_page(r);
                end
            end
            default: fault_count = fault_count + 32'd1;
        endcase
        r.addr  = {dev_addr, 1'b0};
        r.busy  = |busy_q;
        r.comps = done_count;
        r.errs  = fault_count;
        return r;
    endfunction

    task automatic send_event(input plan_row_t row);
        int unsigned  gap;
        xfer_result_t want;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= row.op;
        s_page_mask <= row.mask;
        do @(posedge aclk); while (!s_ready);
        want = schedule_event(row.op, row.mask);
        if (row.typed) begin
            want.start = row.t_start;
            want.kind  = row.t_kind;
            want.page  = row.t_page;
            want.bytes = row.t_bytes;
            want.busy  = row.t_busy;
        end
        pending_requests.push_back(want);
    endtask

    // drop valid and wait until every result word has been taken
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_requests.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_PAGE_COUNT) pg_count = val[3:0];
        else dev_addr = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch_results
        xfer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_requests.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got start %0b page %0d",
                         $time, m_start_transfer, m_page_index);
                fail_count++;
            end else begin
                want = pending_requests.pop_front();
                check_field("start_transfer", 32'(want.start), 32'(m_start_transfer));
                check_field("transfer_kind", 32'(want.kind), 32'(m_transfer_kind));
                check_field("page_index", 32'(want.page), 32'(m_page_index));
                check_field("byte_count", 32'(want.bytes), 32'(m_byte_count));
                check_field("bus_address_byte", 32'(want.addr), 32'(m_bus_address_byte));
                check_field("busy_flag", 32'(want.busy), 32'(m_busy_flag));
                check_field("completions_seen", want.comps, m_completions_seen);
                check_field("errors_seen", want.errs, m_errors_seen);
            end
        end
    end

    // result side: random stalls with occasional stretches of none
    initial begin : drain_results
        int unsigned stall;
        bit          rx_quiet;
        rx_quiet = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 18);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned i;
        int unsigned pick;
        logic [3:0]  count;
        logic [6:0]  addr;
        plan_row_t   row;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].cfg_idx, plan[i].cfg_val);
            end else begin
                send_event(plan[i]);
            end
        end

        row = plan[0];
        row.typed = 1'b0;
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin count = 4'd8; addr = 7'h7F; end
                1: begin count = 4'd1; addr = 7'h00; end
                default: begin
                    pick  = $urandom_range(0, 9);
                    count = (pick == 0) ? 4'd0 :
                            (pick == 9) ? 4'($urandom_range(9, 15)) : 4'(pick);
                    addr  = 7'($urandom_range(0, 127));
                end
            endcase
            // upper bits of the write word are outside the page count field
            write_reg(CFG_PAGE_COUNT, {3'($urandom_range(0, 7)), count});
            write_reg(CFG_DEV_ADDR, addr);
            tx_quiet = ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // mostly completions, so the header/data cycle keeps turning
                pick = $urandom_range(0, 99);
                row.op   = (pick < 18) ? OP_MARK_DIRTY :
                           (pick < 36) ? OP_REFRESH :
                           (pick < 90) ? OP_COMPLETE : OP_ERROR;
                row.mask = 8'($urandom_range(0, 255));
                send_event(row);
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
